// ----- hdl/lehmer_minstd_generator_defines.svh -----
// assertion macros for the checker file of the lehmer generator
// no dependencies; include by bare file name
`ifndef LEHMER_MINSTD_GENERATOR_DEFINES_SVH
`define LEHMER_MINSTD_GENERATOR_DEFINES_SVH

// clocked assertion, masked while reset is asserted
`define LMG_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define LMG_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/lmg_pkg.sv -----
// shared constants and types of the lehmer minstd generator
// no dependencies
package lmg_pkg;

	localparam int unsigned WORD_W = 31;
	localparam int unsigned PROD_W = 2 * WORD_W;
	localparam int unsigned DATA_W = 64;

	localparam logic [WORD_W-1:0] MODULUS      = 31'd2147483647;
	localparam logic [WORD_W-1:0] MULT_NEW     = 31'd48271;
	localparam logic [WORD_W-1:0] MULT_ORIG    = 31'd16807;
	localparam logic [WORD_W-1:0] DEFAULT_SEED = 31'd89482311;
	localparam logic [WORD_W-1:0] ONE          = 31'd1;

	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_ADVANCE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RED_SEED,
		ST_MUL_SCALE,
		ST_RED_SCALE
	} lmg_state_t;

	// control from the sequencer to the shared multiply/reduce unit
	typedef struct packed {
		logic              mul_en;
		logic [WORD_W-1:0] op_a;
		logic [WORD_W-1:0] op_b;
	} lmg_mul_ctrl_t;

endpackage

// ----- hdl/lehmer_minstd_generator.sv -----
// minimal-standard lehmer generator, top level: sequencer, state and stream ports
// depends on lmg_pkg and lmg_mulred
//
// Minimal-standard generator, seed' = seed * a mod (2^31 - 1), with a = 48271,
// or 16807 when cfg_wdata bit 0 was written as 1. Each input transfer either loads
// a seed (tuser 0; zero or 2^31-1 loads 89482311) or advances the generator
// (tuser 1), and yields exactly one output transfer carrying the new seed and
// floor(seed * limit / (2^31 - 1)), which lies in [0, limit), or is 0 for limit 0.
// A single 31x31 multiplier with a product register is used twice per item
// (seed product, then scale product) and each product is folded modulo
// 2^31 - 1 in the following cycle. s_tready is high only while the
// sequencer is idle; a finished result sits in the output register, so the next
// item is taken while it waits, and the block stalls in its last step only if
// the previous result has still not been taken. Write the configuration only
// while idle.
module lehmer_minstd_generator import lmg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_we,
	input  logic              cfg_wdata,     // multiplier_select
	// input stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,       // seed_value[30:0], limit[61:31], zero fill
	input  logic              s_tuser,       // mode
	// output stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata        // raw_value[30:0], scaled_value[61:31], zero fill
);

	lmg_state_t        state_q;
	lmg_state_t        state_nxt;
	logic              mult_sel_q;
	logic [WORD_W-1:0] seed_q;
	logic [WORD_W-1:0] limit_q;
	logic [WORD_W-1:0] raw_q;
	logic [WORD_W-1:0] scaled_q;
	logic              out_valid_q;

	logic [WORD_W-1:0] in_seed;
	logic [WORD_W-1:0] in_limit;
	logic [WORD_W-1:0] mult_const;
	logic [WORD_W-1:0] residue;
	logic [WORD_W-1:0] quotient;
	logic              in_xfer;
	logic              seed_load;
	logic              out_load;
	lmg_mul_ctrl_t     mul_ctrl;

	assign in_seed    = s_tdata[WORD_W-1:0];
	assign in_limit   = s_tdata[PROD_W-1:WORD_W];
	assign mult_const = mult_sel_q ? MULT_ORIG : MULT_NEW;
	assign in_xfer    = s_tvalid && s_tready;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_sel_q <= 1'b0;
		end else if (cfg_we) begin
			mult_sel_q <= cfg_wdata;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_nxt = ST_RED_SEED;
				end
			end
			ST_RED_SEED:  state_nxt = ST_MUL_SCALE;
			ST_MUL_SCALE: state_nxt = ST_RED_SCALE;
			ST_RED_SCALE: begin
				// wait for the output register to free up
				if (!out_valid_q || m_tready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs and multiplier operand selection
	always_comb begin
		s_tready      = 1'b0;
		seed_load     = 1'b0;
		out_load      = 1'b0;
		mul_ctrl      = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready        = 1'b1;
				mul_ctrl.mul_en = in_xfer;
				// a load goes through the same fold as seed * 1
				if (s_tuser == MODE_ADVANCE) begin
					mul_ctrl.op_a = seed_q;
					mul_ctrl.op_b = mult_const;
				end else begin
					mul_ctrl.op_a = in_seed;
					mul_ctrl.op_b = ONE;
				end
			end
			ST_RED_SEED: begin
				seed_load = 1'b1;
			end
			ST_MUL_SCALE: begin
				mul_ctrl.mul_en = 1'b1;
				mul_ctrl.op_a   = seed_q;
				mul_ctrl.op_b   = limit_q;
			end
			ST_RED_SCALE: begin
				out_load = !out_valid_q || m_tready;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	lmg_mulred u_mulred (
		.clk      (clk),
		.ctrl     (mul_ctrl),
		.residue  (residue),
		.quotient (quotient)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seed_q      <= DEFAULT_SEED;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (seed_load) begin
				// a zero residue can only come from a zero or full-scale load
				seed_q <= (residue == '0) ? DEFAULT_SEED : residue;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			limit_q <= in_limit;
		end
		if (out_load) begin
			raw_q    <= seed_q;
			scaled_q <= quotient;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(DATA_W - PROD_W){1'b0}}, scaled_q, raw_q};

endmodule

// ----- hdl/lmg_mulred.sv -----
// shared 31x31 multiplier with product register and fold modulo 2^31 - 1
// depends on lmg_pkg
module lmg_mulred import lmg_pkg::*; (
	input  logic              clk,
	input  lmg_mul_ctrl_t     ctrl,
	output logic [WORD_W-1:0] residue,
	output logic [WORD_W-1:0] quotient
);

	logic [PROD_W-1:0] prod_q;
	logic [WORD_W-1:0] hi;
	logic [WORD_W-1:0] lo;
	logic [WORD_W:0]   fold;
	logic              ge_m;
	logic              ge_2m;

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= PROD_W'(ctrl.op_a) * PROD_W'(ctrl.op_b);
		end
	end

	// p = hi*2^31 + lo = hi*m + (hi + lo), and hi + lo <= 2m
	assign hi    = prod_q[PROD_W-1:WORD_W];
	assign lo    = prod_q[WORD_W-1:0];
	assign fold  = {1'b0, hi} + {1'b0, lo};
	assign ge_m  = (fold >= {1'b0, MODULUS});
	assign ge_2m = (fold >= {MODULUS, 1'b0});

	assign residue  = ge_m ? WORD_W'(fold - {1'b0, MODULUS}) : fold[WORD_W-1:0];
	assign quotient = hi + WORD_W'(ge_m) + WORD_W'(ge_2m);

endmodule

// ----- hdl/lmg_checker.sv -----
// port-level checker for the lehmer minstd generator, bound to the top level
// depends on lmg_pkg and lehmer_minstd_generator_defines.svh
`include "lehmer_minstd_generator_defines.svh"

module lmg_checker import lmg_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata
);

	logic              in_xfer;
	logic              out_stall;
	logic              raw_ok;

	assign in_xfer   = s_tvalid && s_tready;
	assign out_stall = m_tvalid && !m_tready;
	assign raw_ok    = (m_tdata[WORD_W-1:0] != '0) && (m_tdata[WORD_W-1:0] != MODULUS);

	// a result waiting for its transfer is not dropped
	`LMG_ASSERT(a_out_hold, clk, arst_n, out_stall |=> m_tvalid, "output dropped while stalled")
	// the block works on one item at a time
	`LMG_ASSERT(a_busy_after_in, clk, arst_n, in_xfer |=> !s_tready, "ready right after a transfer")
	// a new result never appears right after an input transfer
	`LMG_ASSERT(a_no_early_out, clk, arst_n, $rose(m_tvalid) |-> !$past(in_xfer), "result too early")
	// the seed stays within [1, m-1]
	`LMG_ASSERT_ALWAYS(a_raw_range, clk, m_tvalid |-> raw_ok, "raw value out of range")

endmodule

bind lehmer_minstd_generator lmg_checker u_lmg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- sim/tb.sv -----
// testbench for the lehmer minstd generator: directed and random load/advance items
// depends on lmg_pkg and lehmer_minstd_generator; self-checking with its own prediction
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lmg_pkg::*;

	localparam int unsigned WATCHDOG_CYCLES = 4000;  // cycles with no transfer on either side
	localparam int unsigned HOLD_CYCLES     = 400;   // long receiver hold-off for back-pressure
	localparam int unsigned PHASE_ITEMS     = 225;   // least random items per phase, 8 phases
	localparam int unsigned DRAIN_CYCLES    = 12;    // idle wait after the last draw

	// one expected draw: the seed after the item and its scaled value
	typedef struct {
		logic [WORD_W-1:0] raw;
		logic [WORD_W-1:0] scaled;
	} minstd_draw_t;

	// predicts draws from accepted items and checks output transfers in order
	class minstd_scoreboard;
		logic [WORD_W-1:0] seed;
		logic              mult_sel;
		minstd_draw_t      pending_draws[$];
		int unsigned       failures;

		function new();
			seed = DEFAULT_SEED;
			mult_sel = 1'b0;
			failures = 0;
		endfunction

		// next seed and scaled value for an accepted item
		function void note_item(logic mode, logic [WORD_W-1:0] seed_in,
				logic [WORD_W-1:0] lim);
			bit [63:0] next;
			bit [63:0] mult;
			minstd_draw_t d;
			mult = mult_sel ? 64'(MULT_ORIG) : 64'(MULT_NEW);
			if (mode == MODE_LOAD)
				next = 64'(seed_in) % 64'(MODULUS);
			else
				next = (64'(seed) * mult) % 64'(MODULUS);
			// zero (or a loaded modulus) falls back to the default seed
			seed = (next == 0) ? DEFAULT_SEED : next[WORD_W-1:0];
			d.raw = seed;
			d.scaled = WORD_W'((64'(seed) * 64'(lim)) / 64'(MODULUS));
			pending_draws.push_back(d);
		endfunction

		function void check_result(logic [DATA_W-1:0] data);
			minstd_draw_t d;
			logic [WORD_W-1:0] raw;
			logic [WORD_W-1:0] scaled;
			logic [DATA_W-2*WORD_W-1:0] fill;
			raw = data[WORD_W-1:0];
			scaled = data[2*WORD_W-1:WORD_W];
			fill = data[DATA_W-1:2*WORD_W];
			if (pending_draws.size() == 0) begin
				$error("output transfer with no draw pending: raw_value %0d", raw);
				failures++;
				return;
			end
			d = pending_draws.pop_front();
			if (raw !== d.raw) begin
				$error("raw_value: expected %0d, actual %0d", d.raw, raw);
				failures++;
			end
			if (scaled !== d.scaled) begin
				$error("scaled_value: expected %0d, actual %0d", d.scaled, scaled);
				failures++;
			end
			if (fill !== '0) begin
				$error("tdata fill: expected 0, actual %0h", fill);
				failures++;
			end
		endfunction

		function int unsigned pending();
			return pending_draws.size();
		endfunction

		function bit wrap_up();
			if (pending_draws.size() != 0) begin
				$error("%0d draws never arrived", pending_draws.size());
				failures++;
			end
			return failures == 0;
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_wdata;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;    // seed_value[30:0], limit[61:31], zero fill
	logic              s_tuser;    // mode
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;    // raw_value[30:0], scaled_value[61:31], zero fill

	minstd_scoreboard sb = new();

	// idling knobs, set by the main sequence between phases
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	// receiver hold-off requests; the receiver process serves each once
	int unsigned hold_req = 0;

	lehmer_minstd_generator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// offer one item, with random idle cycles ahead of it; returns just after a falling edge
	task automatic drive_item(input logic mode, input logic [WORD_W-1:0] seed_in,
			input logic [WORD_W-1:0] lim);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			s_tdata = {$urandom, $urandom};   // junk while idle
			s_tuser = 1'($urandom);
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = mode;
		s_tdata = {2'b00, lim, seed_in};
		// sampled before the block updates at this edge
		do @(posedge clk); while (!s_tready);
		sb.note_item(mode, seed_in, lim);
		@(negedge clk);
	endtask

	// wait for every expected draw, leaving the input idle
	task automatic drain();
		s_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// multiplier select write, only while the block is idle
	task automatic write_mult_select(input logic sel);
		cfg_we = 1'b1;
		cfg_wdata = sel;
		@(negedge clk);
		cfg_we = 1'b0;
		cfg_wdata = 1'($urandom);
		sb.mult_sel = sel;
	endtask

	function automatic logic [WORD_W-1:0] rand_seed();
		case ($urandom_range(9))
			0: return '0;
			1: return MODULUS;           // loads the default seed
			2: return MODULUS - ONE;
			3: return WORD_W'($urandom_range(1, 100));
			default: return WORD_W'($urandom);
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] rand_limit();
		case ($urandom_range(9))
			0: return '0;
			1: return ONE;
			2: return '1;
			3: return WORD_W'($urandom_range(2, 1000));
			4: return WORD_W'(1) << $urandom_range(WORD_W - 1);
			default: return WORD_W'($urandom);
		endcase
	endfunction

	// mostly loads followed by runs of advances, some random mode noise
	task automatic random_phase(input int unsigned n);
		int unsigned sent;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(9) < 8) begin
				drive_item(MODE_LOAD, rand_seed(), rand_limit());
				sent++;
				repeat ($urandom_range(1, 20)) begin
					drive_item(MODE_ADVANCE, rand_seed(), rand_limit());
					sent++;
				end
			end else begin
				repeat ($urandom_range(1, 8)) begin
					drive_item(1'($urandom), rand_seed(), rand_limit());
					sent++;
				end
			end
		end
	endtask

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int unsigned hold_left;
		int unsigned hold_served;
		hold_left = 0;
		hold_served = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_served) begin
				hold_served = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_tready = 1'b0;
				hold_left--;
			end else begin
				m_tready = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// output monitor: every output transfer goes to the scoreboard
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_result(m_tdata);
		end
	end

	// watchdog: too long without any transfer ends the run
	initial begin
		int unsigned quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, reset multiplier 48271
		drive_item(MODE_LOAD, '0, '1);                   // zero seed loads the default
		drive_item(MODE_ADVANCE, '0, '0);                // zero limit gives zero
		drive_item(MODE_LOAD, ONE, ONE);                 // smallest seed
		drive_item(MODE_ADVANCE, '1, '1);                // largest limit
		drive_item(MODE_LOAD, MODULUS - ONE, '1);        // largest legal seed
		drive_item(MODE_ADVANCE, '0, 31'd2);
		drive_item(MODE_LOAD, MODULUS, 31'd12345);       // loading the modulus gives default
		drive_item(MODE_ADVANCE, '1, 31'h4000_0000);
		drive_item(MODE_LOAD, 31'h5555_5555, 31'h2AAA_AAAA);
		drive_item(MODE_ADVANCE, 31'h2AAA_AAAA, 31'h5555_5555);
		drive_item(MODE_ADVANCE, '0, ONE);
		drain();

		// directed, original multiplier 16807
		write_mult_select(1'b1);
		drive_item(MODE_LOAD, ONE, '1);
		drive_item(MODE_ADVANCE, '0, '1);                // gives 16807 itself
		drive_item(MODE_ADVANCE, '0, 31'd1000);
		drive_item(MODE_LOAD, MODULUS - ONE, '1);
		drive_item(MODE_ADVANCE, '1, '1);
		drive_item(MODE_LOAD, '0, '0);
		drive_item(MODE_ADVANCE, '0, ONE);
		drain();

		// random phases: idle mode steps every two phases, multiplier alternates
		for (int p = 0; p < 8; p++) begin
			write_mult_select(p[0]);
			case (p / 2)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
				default: begin send_idle_pct = 14; recv_stall_pct = 14; end
			endcase
			// back-pressure: the receiver holds off while the sender keeps offering
			if (p == 1 || p == 6)
				hold_req++;
			random_phase(PHASE_ITEMS);
			drain();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.wrap_up())
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
